// File: design/mssd_pkg.sv
// Shared types, codes and the segment table of the seven-segment shift driver.
package mssd_pkg;

    localparam int SampleWidth = 12;
    localparam int DigitCount  = 4;
    localparam int SegWidth    = 8;

    localparam logic [DigitCount-1:0] LINES_OFF = 4'hF;
    localparam logic                  CMD_TICK  = 1'b0;
    localparam logic                  CMD_LOAD  = 1'b1;

    typedef logic [3:0] bcd_digit_t;
    typedef logic [1:0] digit_phase_t;

    typedef struct packed {
        logic                   cmd;
        logic [SampleWidth-1:0] sample;
    } mssd_in_t;

    typedef struct packed {
        logic                  serial_bit;
        logic                  latch_strobe;
        logic [DigitCount-1:0] digit_lines;
    } mssd_out_t;

    // One refresh frame handed from the digit selection to the shifter.
    typedef struct packed {
        logic [SegWidth-1:0]   seg;
        logic [DigitCount-1:0] on_lines;
    } mssd_frame_t;

    function automatic logic [SegWidth-1:0] seg_lookup(input bcd_digit_t digit);
        logic [SegWidth-1:0] seg;
        case (digit)
            4'd0: seg = 8'hEB;
            4'd1: seg = 8'h88;
            4'd2: seg = 8'hB3;
            4'd3: seg = 8'hBA;
            4'd4: seg = 8'hD8;
            4'd5: seg = 8'h7A;
            4'd6: seg = 8'h7B;
            4'd7: seg = 8'hA8;
            4'd8: seg = 8'hFB;
            4'd9: seg = 8'hFA;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// File: design/mssd_bin2bcd.sv
// Binary to four-digit BCD conversion by parallel compares against digit weights.
module mssd_bin2bcd (
    input  logic [mssd_pkg::SampleWidth-1:0]                        value,
    output logic [mssd_pkg::DigitCount-1:0][3:0]                    digits
);
    import mssd_pkg::*;

    bcd_digit_t        thou, hund, tens, unit;
    logic [9:0]        rem_hund;
    logic [6:0]        rem_tens;
    logic [11:0]       thou_w;
    logic [9:0]        hund_w;
    logic [6:0]        tens_w;

    // Each weight compare is independent; the largest matching multiple wins.
    always_comb begin
        thou = '0;
        for (int k = 1; k <= 4; k++) begin
            if (value >= 12'(k * 1000)) begin
                thou = 4'(k);
            end
        end
        thou_w   = 12'(thou) * 12'd1000;
        rem_hund = 10'(value - thou_w);

        hund = '0;
        for (int k = 1; k <= 9; k++) begin
            if (rem_hund >= 10'(k * 100)) begin
                hund = 4'(k);
            end
        end
        hund_w   = 10'(hund) * 10'd100;
        rem_tens = 7'(rem_hund - hund_w);

        tens = '0;
        for (int k = 1; k <= 9; k++) begin
            if (rem_tens >= 7'(k * 10)) begin
                tens = 4'(k);
            end
        end
        tens_w = 7'(tens) * 7'd10;
        unit   = 4'(rem_tens - tens_w);
    end

    // Index 0 is thousands so the digit phase selects directly.
    assign digits = {unit, tens, hund, thou};

endmodule

// File: design/mssd_seg_shifter.sv
// Output shifter that sends one segment byte as eight items, MSB first.
module mssd_seg_shifter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  frame_valid,
    input  mssd_pkg::mssd_frame_t frame,
    output logic                  free,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mssd_pkg::mssd_out_t   m_data
);
    import mssd_pkg::*;

    logic                  busy_reg, busy_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [SegWidth-1:0]   shift_reg, shift_next;
    logic [DigitCount-1:0] lines_reg, lines_next;
    logic                  last;

    assign last = (cnt_reg == 3'd7);
    assign free = !busy_reg || (m_ready && last);

    always_comb begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        lines_next = lines_reg;
        if (frame_valid && free) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = frame.seg;
            lines_next = frame.on_lines;
        end else if (busy_reg && m_ready) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                cnt_next   = cnt_reg + 3'd1;
                shift_next = {shift_reg[SegWidth-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        lines_reg <= lines_next;
    end

    assign m_valid             = busy_reg;
    assign m_data.serial_bit   = shift_reg[SegWidth-1];
    assign m_data.latch_strobe = last;
    assign m_data.digit_lines  = last ? lines_reg : LINES_OFF;

endmodule

// File: design/mux_seven_segment_shift_driver.sv
// Top level of the multiplexed four-digit seven-segment shift-register driver.
//
//  Channel | Ports                   | Carries
//  --------+-------------------------+------------------------------------------
//  input   | s_valid s_ready s_data  | cmd (tick or load), 12-bit sample
//  result  | m_valid m_ready m_data  | serial_bit, latch_strobe, digit_lines
//
// A load item is taken into the input register and, in the next cycle, its BCD
// digits are written into the held-digit register; it produces no result.
// A refresh tick moves from the input register into the output shifter and then
// gives eight items, one per cycle while m_ready is high; loads flow at one item
// per cycle. The next tick waits in the input register and enters the shifter in
// the same cycle that the last item of the previous frame is taken.
// Reset (aresetn low at a clock edge) clears the phase to thousands, the held
// value to zero and drops all valid flags.
module mux_seven_segment_shift_driver (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mssd_pkg::mssd_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mssd_pkg::mssd_out_t m_data
);
    import mssd_pkg::*;

    // Input register: one item waiting to be processed.
    logic     in_valid_reg, in_valid_next;
    mssd_in_t in_data_reg, in_data_next;

    // Held value kept as BCD digits, index 0 is thousands.
    logic [DigitCount-1:0][3:0] digits_reg, digits_next;
    logic [DigitCount-1:0][3:0] load_digits;
    digit_phase_t               phase_reg, phase_next;

    mssd_frame_t frame;
    logic        shifter_free;
    logic        is_load;
    logic        drain;
    logic        tick_go;

    mssd_bin2bcd u_bin2bcd (
        .value  (in_data_reg.sample),
        .digits (load_digits)
    );

    assign is_load = (in_data_reg.cmd == CMD_LOAD);
    // A load always leaves the input register at once; a tick needs the shifter.
    assign drain   = in_valid_reg && (is_load || shifter_free);
    assign tick_go = in_valid_reg && !is_load && shifter_free;
    assign s_ready = !in_valid_reg || drain;

    // The current digit's segment byte and its active-low select.
    assign frame.seg      = seg_lookup(digits_reg[phase_reg]);
    assign frame.on_lines = LINES_OFF & ~(4'b1000 >> phase_reg);

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        digits_next   = digits_reg;
        phase_next    = phase_reg;
        if (drain) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end
        if (drain && is_load) begin
            digits_next = load_digits;
        end
        if (tick_go) begin
            phase_next = phase_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            digits_reg   <= '0;
            phase_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            digits_reg   <= digits_next;
            phase_reg    <= phase_next;
        end
        in_data_reg <= in_data_next;
    end

    mssd_seg_shifter u_shifter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_valid (tick_go),
        .frame       (frame),
        .free        (shifter_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // The latched item switches on exactly one digit line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.latch_strobe |-> $countones(m_data.digit_lines) == 3)
        else $error("latched item does not select exactly one digit");

    // Shifting items keep every digit line off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.latch_strobe |-> m_data.digit_lines == LINES_OFF)
        else $error("digit line active while shifting");

    // The phase steps by one for each tick sent to the shifter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tick_go |=> phase_reg == $past(phase_reg) + 2'd1)
        else $error("digit phase did not advance after a tick");

    // A pending load never blocks the input; it does not wait for the shifter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && is_load |-> s_ready)
        else $error("pending load blocked the input");

endmodule

// File: dv/mux_seven_segment_shift_driver_tb.sv
// Self-checking testbench for the multiplexed seven-segment shift-register driver.
module mux_seven_segment_shift_driver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mssd_pkg::*;

    // One row of the directed plan. Where the segment byte and the digit lines
    // can be read straight off the behavior, they are typed in and used in place
    // of the predicted frame.
    typedef struct packed {
        mssd_in_t   item;
        logic       typed;
        logic [7:0] seg;
        logic [3:0] lines;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    mssd_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    mssd_out_t m_data;

    // Our own copy of the display state: the value on show and the digit that
    // the next refresh tick will drive.
    logic [11:0]  shown_value;
    digit_phase_t shown_phase;

    // Shift results still owed by the block, oldest first.
    mssd_out_t shift_bits_q[$];

    int wrong_result_count = 0;
    int results_seen       = 0;
    int offered            = 0;

    mux_seven_segment_shift_driver dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard ceiling on the run. The slowest legal run (every result behind the
    // longest receiver stall, every item behind the longest sender gap, plus
    // the one long hold-off) stays well under a fifth of this.
    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Idle length for either side: mostly none, now and then a long stretch.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Segment pattern of one decimal digit on this board's wiring.
    function automatic logic [7:0] glyph_for(int digit);
        case (digit)
            0: return 8'hEB;
            1: return 8'h88;
            2: return 8'hB3;
            3: return 8'hBA;
            4: return 8'hD8;
            5: return 8'h7A;
            6: return 8'h7B;
            7: return 8'hA8;
            8: return 8'hFB;
            default: return 8'hFA;
        endcase
    endfunction

    // Applies one accepted item to our display state. A load only swaps the
    // value on show; a tick yields the frame for the current digit and then
    // moves on to the next digit, wrapping from units back to thousands.
    task automatic advance_display(input mssd_in_t it, output logic is_tick,
                                   output mssd_frame_t frame);
        int digit;
        is_tick = 1'b0;
        frame   = '0;
        if (it.cmd == CMD_LOAD) begin
            shown_value = it.sample;
        end else begin
            case (shown_phase)
                2'd0: digit = shown_value / 1000;
                2'd1: digit = (shown_value % 1000) / 100;
                2'd2: digit = (shown_value % 100) / 10;
                default: digit = shown_value % 10;
            endcase
            frame.seg      = glyph_for(digit);
            // Digit lines are active low with thousands on the top bit.
            frame.on_lines = LINES_OFF & ~(4'b1000 >> shown_phase);
            is_tick        = 1'b1;
            shown_phase    = shown_phase + 2'd1;
        end
    endtask

    // A frame leaves as eight results, segment byte MSB first. All digits stay
    // dark while bits are shifting; the last result latches and lights one.
    task automatic owe_frame(input mssd_frame_t frame);
        mssd_out_t r;
        for (int i = 0; i < 8; i++) begin
            r.serial_bit   = frame.seg[7 - i];
            r.latch_strobe = (i == 7);
            r.digit_lines  = (i == 7) ? frame.on_lines : LINES_OFF;
            shift_bits_q.push_back(r);
        end
    endtask

    function automatic stim_row_t mk_row(logic cmd, logic [11:0] sample, logic typed,
                                         logic [7:0] seg, logic [3:0] lines);
        stim_row_t row;
        row.item.cmd    = cmd;
        row.item.sample = sample;
        row.typed       = typed;
        row.seg         = seg;
        row.lines       = lines;
        return row;
    endfunction

    // Offers one item and holds it until the block takes it. The sender may idle
    // before each item, except in every third run of 25 items where it
    // streams back to back. The prediction is made at the accepting edge, so
    // it always lands before the first result that the item can cause.
    task automatic send_item(input mssd_in_t it, input logic typed,
                             input mssd_frame_t typed_frame);
        int          gap;
        logic        is_tick;
        mssd_frame_t frame;
        gap = (((offered / 25) % 3) == 1) ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        offered++;
        advance_display(it, is_tick, frame);
        if (is_tick) begin
            owe_frame(typed ? typed_frame : frame);
        end
    endtask

    // Drops valid and waits for every owed result. At least one edge passes so
    // that valid is never lowered and raised within the same time step.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (shift_bits_q.size() != 0);
    endtask

    task automatic send_random(input logic cmd);
        mssd_in_t it;
        int       roll;
        it.cmd = cmd;
        roll   = $urandom_range(0, 15);
        // Lean on the edges of the range and on the thousands boundary now and
        // then; the sample is random on ticks too, where it must be ignored.
        case (roll)
            0: it.sample = 12'd0;
            1: it.sample = 12'd4095;
            2: it.sample = 12'd999;
            3: it.sample = 12'd1000;
            default: it.sample = 12'($urandom_range(0, 4095));
        endcase
        send_item(it, 1'b0, '0);
    endtask

    function automatic void flag_result(string what, mssd_out_t want, mssd_out_t got);
        wrong_result_count++;
        if (wrong_result_count <= 10) begin
            $display("%0t: %s: expected bit=%b latch=%b lines=%b, got bit=%b latch=%b lines=%b",
                     $realtime, what, want.serial_bit, want.latch_strobe, want.digit_lines,
                     got.serial_bit, got.latch_strobe, got.digit_lines);
        end
    endfunction

    // Result checker: every accepted result must match the oldest owed one,
    // field by field.
    always @(posedge aclk) begin : check_results
        mssd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (shift_bits_q.size() == 0) begin
                flag_result("result with none owed", '0, m_data);
            end else begin
                want = shift_bits_q.pop_front();
                if (m_data.serial_bit !== want.serial_bit ||
                    m_data.latch_strobe !== want.latch_strobe ||
                    m_data.digit_lines !== want.digit_lines) begin
                    flag_result("wrong result", want, m_data);
                end
            end
        end
    end

    // Receiver. It alternates between stretches of always-ready and stretches
    // with random stalls. Once some 400 results have passed it holds off in one go,
    // while the sender keeps offering, so that both the shifter and the input
    // register fill and the input stalls.
    initial begin : result_sink
        int   gap_left;
        int   hold_left;
        int   cyc;
        logic hold_done;
        logic next_ready;
        gap_left  = 0;
        hold_left = 0;
        cyc       = 0;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            cyc++;
            if (!hold_done && results_seen >= 400) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                next_ready = 1'b0;
            end else if (((cyc / 200) % 4) == 0) begin
                next_ready = 1'b1;
            end else begin
                gap_left   = idle_len();
                next_ready = (gap_left == 0);
                if (gap_left > 0) begin
                    gap_left--;
                end
            end
            m_ready <= next_ready;
            @(posedge aclk);
        end
    end

    // Sender: reset, the directed plan, then random items shaped mostly as
    // load-then-four-ticks sequences so that every digit of each new value is
    // shown, mixed with lone ticks and back-to-back loads.
    initial begin : stimulus
        stim_row_t   plan[$];
        mssd_frame_t typed_frame;
        logic        paused_mid;
        int          pick;

        shown_value = '0;
        shown_phase = '0;
        paused_mid  = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;

        // Straight out of reset the value is zero and the first tick shows
        // thousands; the tick sample is junk that must be ignored.
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b1, 8'hEB, 4'b0111));
        plan.push_back(mk_row(CMD_TICK, 12'hFFF,  1'b1, 8'hEB, 4'b1011));
        plan.push_back(mk_row(CMD_TICK, 12'h555,  1'b1, 8'hEB, 4'b1101));
        plan.push_back(mk_row(CMD_TICK, 12'hAAA,  1'b1, 8'hEB, 4'b1110));
        // Largest value: thousands digit can only reach 4.
        plan.push_back(mk_row(CMD_LOAD, 12'd4095, 1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b1, 8'hD8, 4'b0111));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b1, 8'hEB, 4'b1011));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b1, 8'hFA, 4'b1101));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b1, 8'h7A, 4'b1110));
        // Back-to-back loads; only the second one should be shown.
        plan.push_back(mk_row(CMD_LOAD, 12'd0,    1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_LOAD, 12'd1234, 1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b0, 8'h00, 4'h0));
        // A load in the middle of a refresh round must not move the digit.
        plan.push_back(mk_row(CMD_LOAD, 12'd3789, 1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b0, 8'h00, 4'h0));
        // Fills in the digits not yet shown, so all ten patterns appear.
        plan.push_back(mk_row(CMD_LOAD, 12'd2637, 1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_LOAD, 12'd1000, 1'b0, 8'h00, 4'h0));
        plan.push_back(mk_row(CMD_TICK, 12'd0,    1'b0, 8'h00, 4'h0));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            typed_frame.seg      = plan[i].seg;
            typed_frame.on_lines = plan[i].lines;
            send_item(plan[i].item, plan[i].typed, typed_frame);
        end
        wait_drained();

        while (offered < 23 + 180) begin
            // Once, halfway through, stop offering until all results are in.
            if (!paused_mid && offered >= 23 + 90) begin
                paused_mid = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                send_random(CMD_LOAD);
                repeat (4) send_random(CMD_TICK);
            end else if (pick < 8) begin
                send_random(CMD_TICK);
            end else begin
                send_random(CMD_LOAD);
                send_random(CMD_LOAD);
            end
        end

        wait_drained();
        // Keep running to catch any stray result after the last frame.
        repeat (20) @(posedge aclk);
        if (wrong_result_count == 0 && shift_bits_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
